### rtl/lar_pkg.sv
package lar_pkg;

    localparam int ROW_BITS       = 7;
    localparam int COL_BITS       = 12;
    localparam int RANGE_BITS     = 20;
    localparam int CFG_BITS       = 13;
    localparam int ANG_BITS       = 32;
    localparam int Q_BITS         = 34;
    localparam int PRESCALE_SHIFT = 16;

    localparam logic [CFG_BITS-1:0]   CFG_RESET    = 13'd1024;
    localparam logic [RANGE_BITS-1:0] RANGE_MAX    = 20'hF_FFFF;
    localparam logic [ANG_BITS-1:0]   QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_BITS-1:0]   HALF_TURN    = 32'h8000_0000;

    // arctan(2^-i) in binary-angle units, one turn = 2^32
    localparam logic [ANG_BITS-1:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic                x_nonneg;
        logic                y_pos;
        logic                ay_zero;
        logic                ax_zero;
    } t_ctl;

endpackage

### rtl/lar_front.sv
module lar_front #(
    parameter int COORD_BITS = 20,
    parameter int MAX_ROWS   = 128
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [COORD_BITS-1:0]     i_point_x,
    input  logic signed [COORD_BITS-1:0]     i_point_y,
    input  logic signed [COORD_BITS-1:0]     i_point_z,
    input  logic                             i_point_present,
    input  logic [lar_pkg::ROW_BITS-1:0]     i_beam_row,
    output logic                             o_keep,
    output logic signed [COORD_BITS+18:0]    o_cx,
    output logic signed [COORD_BITS+18:0]    o_cy,
    output logic [2*COORD_BITS-1:0]          o_s,
    output lar_pkg::t_ctl                    o_ctl
);
    import lar_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int W  = COORD_BITS + 19;

    logic [CB-1:0]   n_ax, n_ay, n_az;
    t_ctl            n_ctl;
    logic [CB-1:0]   r_ax, r_ay, r_az;
    t_ctl            r_ctl_a;
    logic [2*CB-1:0] r_sx, r_sy, r_sz;
    logic [CB-1:0]   r_ax_b, r_ay_b;
    t_ctl            r_ctl_b;
    logic [2*CB-1:0] r_s;
    logic [W-1:0]    r_cx, r_cy;
    t_ctl            r_ctl_c;

    assign o_keep = i_point_present && (32'(i_beam_row) < MAX_ROWS);

    always_comb begin
        n_ax           = i_point_x[CB-1] ? CB'(-i_point_x) : CB'(i_point_x);
        n_ay           = i_point_y[CB-1] ? CB'(-i_point_y) : CB'(i_point_y);
        n_az           = i_point_z[CB-1] ? CB'(-i_point_z) : CB'(i_point_z);
        n_ctl.row      = i_beam_row;
        n_ctl.x_nonneg = !i_point_x[CB-1];
        n_ctl.y_pos    = !i_point_y[CB-1] && (i_point_y != '0);
        n_ctl.ay_zero  = (i_point_y == '0);
        n_ctl.ax_zero  = (i_point_x == '0);
    end

    // abs, squares, then sum and vector prescale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_az    <= n_az;
            r_ctl_a <= n_ctl;
            r_sx    <= (2*CB)'(r_ax) * (2*CB)'(r_ax);
            r_sy    <= (2*CB)'(r_ay) * (2*CB)'(r_ay);
            r_sz    <= (2*CB)'(r_az) * (2*CB)'(r_az);
            r_ax_b  <= r_ax;
            r_ay_b  <= r_ay;
            r_ctl_b <= r_ctl_a;
            r_s     <= r_sx + r_sy + r_sz;
            r_cx    <= {3'b000, r_ax_b, PRESCALE_SHIFT'(0)};
            r_cy    <= {3'b000, r_ay_b, PRESCALE_SHIFT'(0)};
            r_ctl_c <= r_ctl_b;
        end
    end

    assign o_cx  = signed'(r_cx);
    assign o_cy  = signed'(r_cy);
    assign o_s   = r_s;
    assign o_ctl = r_ctl_c;

endmodule

### rtl/lar_cell.sv
module lar_cell #(
    parameter int IDX           = 0,
    parameter int COORD_BITS    = 20,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [COORD_BITS+18:0]     i_cx,
    input  logic signed [COORD_BITS+18:0]     i_cy,
    input  logic signed [lar_pkg::Q_BITS-1:0] i_q,
    input  logic [2*COORD_BITS-1:0]           i_s,
    input  logic [COORD_BITS+1:0]             i_rem,
    input  logic [COORD_BITS-1:0]             i_root,
    input  lar_pkg::t_ctl                     i_ctl,
    output logic signed [COORD_BITS+18:0]     o_cx,
    output logic signed [COORD_BITS+18:0]     o_cy,
    output logic signed [lar_pkg::Q_BITS-1:0] o_q,
    output logic [2*COORD_BITS-1:0]           o_s,
    output logic [COORD_BITS+1:0]             o_rem,
    output logic [COORD_BITS-1:0]             o_root,
    output lar_pkg::t_ctl                     o_ctl
);
    import lar_pkg::*;

    localparam int  CB      = COORD_BITS;
    localparam int  W       = COORD_BITS + 19;
    localparam bit  DO_ROT  = (IDX < CORDIC_STAGES);
    localparam bit  DO_SQRT = (IDX < COORD_BITS);

    logic signed [Q_BITS-1:0] w_atan;
    logic [CB+3:0]            w_rem2, w_trial;
    logic signed [W-1:0]      n_cx, n_cy;
    logic signed [Q_BITS-1:0] n_q;
    logic [2*CB-1:0]          n_s;
    logic [CB+1:0]            n_rem;
    logic [CB-1:0]            n_root;
    logic signed [W-1:0]      r_cx, r_cy;
    logic signed [Q_BITS-1:0] r_q;
    logic [2*CB-1:0]          r_s;
    logic [CB+1:0]            r_rem;
    logic [CB-1:0]            r_root;
    t_ctl                     r_ctl;

    always_comb begin
        w_atan  = signed'({2'b00, ATAN_TURNS[IDX]});
        w_rem2  = {i_rem, i_s[2*CB-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        n_cx    = i_cx;
        n_cy    = i_cy;
        n_q     = i_q;
        n_s     = i_s;
        n_rem   = i_rem;
        n_root  = i_root;
        if (DO_ROT) begin
            // rotate toward the x axis
            if (i_cy > 0) begin
                n_cx = i_cx + (i_cy >>> IDX);
                n_cy = i_cy - (i_cx >>> IDX);
                n_q  = i_q + w_atan;
            end else begin
                n_cx = i_cx - (i_cy >>> IDX);
                n_cy = i_cy + (i_cx >>> IDX);
                n_q  = i_q - w_atan;
            end
        end
        if (DO_SQRT) begin
            // one root digit per cell
            n_s = {i_s[2*CB-3:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                n_rem  = (CB+2)'(w_rem2 - w_trial);
                n_root = {i_root[CB-2:0], 1'b1};
            end else begin
                n_rem  = w_rem2[CB+1:0];
                n_root = {i_root[CB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_q    <= n_q;
            r_s    <= n_s;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_ctl  <= i_ctl;
        end
    end

    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
    assign o_q    = r_q;
    assign o_s    = r_s;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_ctl  = r_ctl;

endmodule

### rtl/lar_back.sv
module lar_back #(
    parameter int COORD_BITS  = 20,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [lar_pkg::CFG_BITS-1:0]      i_col_cnt,
    input  logic signed [lar_pkg::Q_BITS-1:0] i_q,
    input  logic [COORD_BITS+1:0]             i_rem,
    input  logic [COORD_BITS-1:0]             i_root,
    input  lar_pkg::t_ctl                     i_ctl,
    output logic [lar_pkg::ROW_BITS-1:0]      o_row,
    output logic [lar_pkg::COL_BITS-1:0]      o_column,
    output logic [lar_pkg::RANGE_BITS-1:0]    o_range
);
    import lar_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int RW = (CB + 1 > RANGE_BITS) ? CB + 1 : RANGE_BITS;

    logic [ANG_BITS-1:0]          w_qc, w_m, n_ang;
    logic [CB:0]                  w_r1;
    logic [RW-1:0]                w_rx;
    logic [RANGE_BITS-1:0]        n_range;
    logic [CFG_BITS-1:0]          w_cols, n_col;
    logic [ANG_BITS+CFG_BITS-1:0] w_prod;
    logic [ANG_BITS-1:0]          r_ang;
    logic [RANGE_BITS-1:0]        r_range_a;
    logic [ROW_BITS-1:0]          r_row_a;
    logic [COL_BITS-1:0]          r_col;
    logic [RANGE_BITS-1:0]        r_range;
    logic [ROW_BITS-1:0]          r_row;

    always_comb begin
        if (i_ctl.ay_zero) begin
            w_qc = '0;
        end else if (i_ctl.ax_zero) begin
            w_qc = QUARTER_TURN;
        end else if (i_q < 0) begin
            w_qc = '0;
        end else if (i_q > signed'({2'b00, QUARTER_TURN})) begin
            w_qc = QUARTER_TURN;
        end else begin
            w_qc = i_q[ANG_BITS-1:0];
        end
        w_m   = i_ctl.x_nonneg ? w_qc : HALF_TURN - w_qc;
        n_ang = i_ctl.y_pos ? ANG_BITS'(0) - w_m : w_m;

        // round half up, then saturate
        w_r1    = {1'b0, i_root} + (CB+1)'(i_rem > {2'b00, i_root});
        w_rx    = RW'(w_r1);
        n_range = (w_rx > RW'(RANGE_MAX)) ? RANGE_MAX : w_rx[RANGE_BITS-1:0];

        if (i_col_cnt == '0) begin
            w_cols = CFG_BITS'(1);
        end else if (32'(i_col_cnt) > MAX_COLUMNS) begin
            w_cols = CFG_BITS'(MAX_COLUMNS);
        end else begin
            w_cols = i_col_cnt;
        end
        w_prod = (ANG_BITS+CFG_BITS)'(r_ang) * (ANG_BITS+CFG_BITS)'(w_cols);
        n_col  = w_prod[ANG_BITS+CFG_BITS-1:ANG_BITS];
        if (n_col >= w_cols) begin
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang     <= n_ang;
            r_range_a <= n_range;
            r_row_a   <= i_ctl.row;
            r_col     <= n_col[COL_BITS-1:0];
            r_range   <= r_range_a;
            r_row     <= r_row_a;
        end
    end

    assign o_row    = r_row;
    assign o_column = r_col;
    assign o_range  = r_range;

endmodule

### rtl/lidar_azimuth_range_projection.sv
// throughput: one item per cycle while the input is not stalled, set by the chain of
// one-step cells (rotation plus root digit)
// input stalls only while the output skid slot holds an item
// reset (synchronous, active low) empties the pipeline and sets column_count to 1024
module lidar_azimuth_range_projection #(
    parameter int COORD_BITS    = 20,
    parameter int MAX_COLUMNS   = 4096,
    parameter int MAX_ROWS      = 128,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic signed [COORD_BITS-1:0]      i_point_z,
    input  logic                              i_point_present,
    input  logic [lar_pkg::ROW_BITS-1:0]      i_beam_row,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lar_pkg::ROW_BITS-1:0]      o_out_row,
    output logic [lar_pkg::COL_BITS-1:0]      o_out_column,
    output logic [lar_pkg::RANGE_BITS-1:0]    o_out_range,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lar_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import lar_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int W  = COORD_BITS + 19;
    localparam int NC = (CORDIC_STAGES > COORD_BITS) ? CORDIC_STAGES : COORD_BITS;
    localparam int NS = NC + 5;

    logic                     w_en, w_acc, w_keep;
    logic signed [W-1:0]      w_cx   [NC+1];
    logic signed [W-1:0]      w_cy   [NC+1];
    logic signed [Q_BITS-1:0] w_q    [NC+1];
    logic [2*CB-1:0]          w_s    [NC+1];
    logic [CB+1:0]            w_rem  [NC+1];
    logic [CB-1:0]            w_root [NC+1];
    t_ctl                     w_ctl  [NC+1];
    logic [ROW_BITS-1:0]      w_row;
    logic [COL_BITS-1:0]      w_col;
    logic [RANGE_BITS-1:0]    w_rng;
    logic                     w_push, w_pop;

    logic [CFG_BITS-1:0]      r_col_cnt;
    logic [NS-1:0]            r_vld;
    logic                     r_out_vld, r_skid_vld;
    logic [ROW_BITS-1:0]      r_out_row, r_skid_row;
    logic [COL_BITS-1:0]      r_out_col, r_skid_col;
    logic [RANGE_BITS-1:0]    r_out_rng, r_skid_rng;
    logic                     n_out_vld, n_skid_vld, n_out_load, n_out_from_skid;

    assign w_en  = !r_skid_vld;
    assign w_acc = i_in_valid && w_en;

    lar_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_point_present (i_point_present),
        .i_beam_row      (i_beam_row),
        .o_keep          (w_keep),
        .o_cx            (w_cx[0]),
        .o_cy            (w_cy[0]),
        .o_s             (w_s[0]),
        .o_ctl           (w_ctl[0])
    );

    assign w_q[0]    = '0;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        lar_cell #(
            .IDX           (k),
            .COORD_BITS    (COORD_BITS),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cx   (w_cx[k]),
            .i_cy   (w_cy[k]),
            .i_q    (w_q[k]),
            .i_s    (w_s[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .i_ctl  (w_ctl[k]),
            .o_cx   (w_cx[k+1]),
            .o_cy   (w_cy[k+1]),
            .o_q    (w_q[k+1]),
            .o_s    (w_s[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1]),
            .o_ctl  (w_ctl[k+1])
        );
    end

    lar_back #(
        .COORD_BITS  (COORD_BITS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_col_cnt (r_col_cnt),
        .i_q       (w_q[NC]),
        .i_rem     (w_rem[NC]),
        .i_root    (w_root[NC]),
        .i_ctl     (w_ctl[NC]),
        .o_row     (w_row),
        .o_column  (w_col),
        .o_range   (w_rng)
    );

    // output register with skid slot
    assign w_push = w_en && r_vld[NS-1];
    assign w_pop  = r_out_vld && !i_out_stall;

    always_comb begin
        n_out_vld       = r_out_vld;
        n_skid_vld      = r_skid_vld;
        n_out_load      = 1'b0;
        n_out_from_skid = 1'b0;
        if (!r_out_vld || w_pop) begin
            if (r_skid_vld) begin
                n_out_vld       = 1'b1;
                n_skid_vld      = 1'b0;
                n_out_from_skid = 1'b1;
            end else begin
                n_out_vld  = w_push;
                n_out_load = w_push;
            end
        end else if (w_push) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= CFG_RESET;
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_col_cnt <= i_cfg_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[NS-2:0], w_acc && w_keep};
            end
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_from_skid) begin
            r_out_row <= r_skid_row;
            r_out_col <= r_skid_col;
            r_out_rng <= r_skid_rng;
        end else if (n_out_load) begin
            r_out_row <= w_row;
            r_out_col <= w_col;
            r_out_rng <= w_rng;
        end
        if (w_push && r_out_vld && !w_pop) begin
            r_skid_row <= w_row;
            r_skid_col <= w_col;
            r_skid_rng <= w_rng;
        end
    end

    assign o_in_stall   = r_skid_vld;
    assign o_out_valid  = r_out_vld;
    assign o_out_row    = r_out_row;
    assign o_out_column = r_out_col;
    assign o_out_range  = r_out_rng;
    assign o_cfg_ready  = 1'b1;

endmodule

### rtl/lar_checker.sv
module lar_checker #(
    parameter int MAX_ROWS = 128
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_stall,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic [lar_pkg::ROW_BITS-1:0]   o_out_row,
    input logic [lar_pkg::COL_BITS-1:0]   o_out_column,
    input logic [lar_pkg::RANGE_BITS-1:0] o_out_range
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not cleared by reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_row)
            && $stable(o_out_column) && $stable(o_out_range))
        else $error("stalled output item changed");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_row) < MAX_ROWS))
        else $error("row beyond image height delivered");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall raised without output back-pressure");

endmodule

bind lidar_azimuth_range_projection lar_checker #(.MAX_ROWS(MAX_ROWS)) u_lar_checker (.*);
